/* rtl/rsp_pkg.sv */
// Shared types, widths, register map and reset values for the ramp setpoint PI controller.
package rsp_pkg;

  localparam int TIME_W  = 24;
  localparam int POS_W   = 32;
  localparam int VEL_W   = 24;
  localparam int GAIN_W  = 32;
  localparam int CMD_W   = 48;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam logic [VEL_W-1:0]  RST_DESIRED_VELOCITY = 24'd26214;
  localparam logic [TIME_W-1:0] RST_ACCEL_TIME       = 24'd65536;
  localparam logic [VEL_W-1:0]  RST_ACCEL_RATE       = 24'd26214;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN        = 32'd98304000;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_DT    = 32'd6554;

  typedef enum logic [2:0] {
    REG_DESIRED_VELOCITY = 3'd0,
    REG_ACCEL_TIME       = 3'd1,
    REG_ACCEL_RATE       = 3'd2,
    REG_PROP_GAIN        = 3'd3,
    REG_INTEG_GAIN_DT    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [VEL_W-1:0]  desired_velocity;
    logic [TIME_W-1:0] accel_time;
    logic [VEL_W-1:0]  accel_rate;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain_dt;
  } cfg_t;

  // One bit per datapath step; the controller raises at most one at a time.
  typedef struct packed {
    logic load;
    logic sq;
    logic ramp;
    logic vel;
    logic sp;
    logic err;
    logic mag;
    logic p_hi;
    logic p_lo;
    logic i_hi;
    logic i_lo;
    logic sum;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  drive_command;
    logic [POS_W-1:0]  setpoint_position;
    logic [VEL_W-1:0]  setpoint_velocity;
    logic [VEL_W-1:0]  setpoint_accel;
    logic [POS_W-1:0]  position_error;
  } result_t;

endpackage

/* rtl/rsp_ifs.sv */
// Valid/ready channel interfaces for tick requests and controller results.
interface rsp_in_if;
  logic                              valid;
  logic                              ready;
  logic        [rsp_pkg::TIME_W-1:0] time_now;
  logic signed [rsp_pkg::POS_W-1:0]  measured_position;

  modport source (output valid, time_now, measured_position, input ready);
  modport sink   (input valid, time_now, measured_position, output ready);
endinterface

interface rsp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rsp_pkg::CMD_W-1:0] drive_command;
  logic signed [rsp_pkg::POS_W-1:0] setpoint_position;
  logic        [rsp_pkg::VEL_W-1:0] setpoint_velocity;
  logic        [rsp_pkg::VEL_W-1:0] setpoint_accel;
  logic signed [rsp_pkg::POS_W-1:0] position_error;

  modport source (output valid, drive_command, setpoint_position, setpoint_velocity,
                  setpoint_accel, position_error, input ready);
  modport sink   (input valid, drive_command, setpoint_position, setpoint_velocity,
                  setpoint_accel, position_error, output ready);
endinterface

/* rtl/rsp_cfg.sv */
// APB configuration register file.
module rsp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsp_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsp_pkg::DATA_W-1:0]  pwdata,
  output logic [rsp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rsp_pkg::cfg_t               cfg
);

  logic               wr_en;
  rsp_pkg::reg_idx_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rsp_pkg::reg_idx_t'(paddr[rsp_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.desired_velocity <= rsp_pkg::RST_DESIRED_VELOCITY;
      cfg.accel_time       <= rsp_pkg::RST_ACCEL_TIME;
      cfg.accel_rate       <= rsp_pkg::RST_ACCEL_RATE;
      cfg.prop_gain        <= rsp_pkg::RST_PROP_GAIN;
      cfg.integ_gain_dt    <= rsp_pkg::RST_INTEG_GAIN_DT;
    end else if (wr_en) begin
      case (idx)
        rsp_pkg::REG_DESIRED_VELOCITY: cfg.desired_velocity <= pwdata[rsp_pkg::VEL_W-1:0];
        rsp_pkg::REG_ACCEL_TIME:       cfg.accel_time       <= pwdata[rsp_pkg::TIME_W-1:0];
        rsp_pkg::REG_ACCEL_RATE:       cfg.accel_rate       <= pwdata[rsp_pkg::VEL_W-1:0];
        rsp_pkg::REG_PROP_GAIN:        cfg.prop_gain        <= pwdata;
        rsp_pkg::REG_INTEG_GAIN_DT:    cfg.integ_gain_dt    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back, zero beyond the map
  always_comb begin
    case (idx)
      rsp_pkg::REG_DESIRED_VELOCITY: prdata = {8'd0, cfg.desired_velocity};
      rsp_pkg::REG_ACCEL_TIME:       prdata = {8'd0, cfg.accel_time};
      rsp_pkg::REG_ACCEL_RATE:       prdata = {8'd0, cfg.accel_rate};
      rsp_pkg::REG_PROP_GAIN:        prdata = cfg.prop_gain;
      rsp_pkg::REG_INTEG_GAIN_DT:    prdata = cfg.integ_gain_dt;
      default:                       prdata = '0;
    endcase
  end

endmodule

/* rtl/rsp_ctrl.sv */
// Sequencer: steps one tick through the datapath and owns the result valid.
module rsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_pkg::dp_cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_SQ   = 13'b0000000000010,
    ST_RAMP = 13'b0000000000100,
    ST_VEL  = 13'b0000000001000,
    ST_SP   = 13'b0000000010000,
    ST_ERR  = 13'b0000000100000,
    ST_MAG  = 13'b0000001000000,
    ST_P_HI = 13'b0000010000000,
    ST_P_LO = 13'b0000100000000,
    ST_I_HI = 13'b0001000000000,
    ST_I_LO = 13'b0010000000000,
    ST_SUM  = 13'b0100000000000,
    ST_CMD  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = ST_RAMP;
      end
      ST_RAMP: begin
        cmd.ramp   = 1'b1;
        state_next = ST_VEL;
      end
      ST_VEL: begin
        cmd.vel    = 1'b1;
        state_next = ST_SP;
      end
      ST_SP: begin
        cmd.sp     = 1'b1;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.err    = 1'b1;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = ST_P_HI;
      end
      ST_P_HI: begin
        cmd.p_hi   = 1'b1;
        state_next = ST_P_LO;
      end
      ST_P_LO: begin
        cmd.p_lo   = 1'b1;
        state_next = ST_I_HI;
      end
      ST_I_HI: begin
        cmd.i_hi   = 1'b1;
        state_next = ST_I_LO;
      end
      ST_I_LO: begin
        cmd.i_lo   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_CMD;
      end
      ST_CMD: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/rsp_dp.sv */
// Datapath: shared 33x24 multiplier, setpoint, error and PI update registers.
module rsp_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rsp_pkg::dp_cmd_t           cmd,
  input  rsp_pkg::cfg_t              cfg,
  input  logic [rsp_pkg::TIME_W-1:0] in_time,
  input  logic [rsp_pkg::POS_W-1:0]  in_meas,
  output rsp_pkg::result_t           res
);

  localparam logic [31:0] ERR_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] ERR_MIN = 32'h8000_0000;
  localparam logic [47:0] CMD_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] CMD_MIN = 48'h8000_0000_0000;

  logic [23:0] t_q;
  logic [31:0] meas_q;
  logic        accel_q;

  logic [32:0] mul_a;
  logic [23:0] mul_b;
  logic [23:0] base;
  logic [56:0] prod;

  logic [38:0] ramp_q;
  logic [39:0] sp_sum;
  logic [31:0] sp_q;
  logic [23:0] vel_q;
  logic [23:0] acc_q;
  logic [32:0] sp_diff;
  logic [31:0] err_q;
  logic [32:0] d_p;
  logic [32:0] d_i;
  logic [32:0] mag_p_q;
  logic [32:0] mag_i_q;
  logic        neg_p_q;
  logic        neg_i_q;
  logic [48:0] hi_q;
  logic [49:0] pmag_q;
  logic [49:0] imag_sum;
  logic [48:0] imag_q;
  logic [51:0] pterm;
  logic [51:0] part_q;
  logic [53:0] iterm;
  logic [53:0] total;
  logic [47:0] cmd_sat;
  logic [31:0] prev_err;
  logic [47:0] prev_cmd;

  assign base = accel_q ? t_q : cfg.accel_time;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq) begin
      mul_a = {9'd0, base};
      mul_b = base;
    end else if (cmd.ramp) begin
      mul_a = {1'b0, prod[47:16]};
      mul_b = cfg.accel_rate;
    end else if (cmd.vel) begin
      if (accel_q) begin
        mul_a = {9'd0, t_q};
        mul_b = cfg.accel_rate;
      end else begin
        mul_a = {9'd0, t_q - cfg.accel_time};
        mul_b = cfg.desired_velocity;
      end
    end else if (cmd.p_hi) begin
      mul_a = mag_p_q;
      mul_b = {8'd0, cfg.prop_gain[31:16]};
    end else if (cmd.p_lo) begin
      mul_a = mag_p_q;
      mul_b = {8'd0, cfg.prop_gain[15:0]};
    end else if (cmd.i_hi) begin
      mul_a = mag_i_q;
      mul_b = {8'd0, cfg.integ_gain_dt[31:16]};
    end else if (cmd.i_lo) begin
      mul_a = mag_i_q;
      mul_b = {8'd0, cfg.integ_gain_dt[15:0]};
    end
  end

  assign sp_sum   = {1'b0, ramp_q} + (accel_q ? 40'd0 : {8'd0, prod[47:16]});
  assign sp_diff  = {sp_q[31], sp_q} - {meas_q[31], meas_q};
  assign d_p      = {err_q[31], err_q} - {prev_err[31], prev_err};
  assign d_i      = {err_q[31], err_q} + {prev_err[31], prev_err};
  assign imag_sum = {1'b0, hi_q} + {17'd0, prod[48:16]};
  assign pterm    = neg_p_q ? (52'd0 - {2'd0, pmag_q}) : {2'd0, pmag_q};
  assign iterm    = neg_i_q ? (54'd0 - {5'd0, imag_q}) : {5'd0, imag_q};
  assign total    = {{2{part_q[51]}}, part_q} + iterm;
  assign cmd_sat  = (total[53:47] == 7'h00 || total[53:47] == 7'h7F) ? total[47:0]
                  : (total[53] ? CMD_MIN : CMD_MAX);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      t_q     <= in_time;
      meas_q  <= in_meas;
      accel_q <= (in_time < cfg.accel_time);
    end
    if (cmd.vel) begin
      ramp_q <= prod[55:17];
    end
    if (cmd.sp) begin
      sp_q  <= (sp_sum[39:31] != 9'd0) ? ERR_MAX : sp_sum[31:0];
      if (accel_q) begin
        vel_q <= (prod[47:40] != 8'd0) ? 24'hFF_FFFF : prod[39:16];
        acc_q <= cfg.accel_rate;
      end else begin
        vel_q <= cfg.desired_velocity;
        acc_q <= '0;
      end
    end
    if (cmd.err) begin
      err_q <= (sp_diff[32] != sp_diff[31]) ? (sp_diff[32] ? ERR_MIN : ERR_MAX)
                                            : sp_diff[31:0];
    end
    if (cmd.mag) begin
      neg_p_q <= d_p[32];
      mag_p_q <= d_p[32] ? (33'd0 - d_p) : d_p;
      neg_i_q <= d_i[32];
      mag_i_q <= d_i[32] ? (33'd0 - d_i) : d_i;
    end
    if (cmd.p_lo || cmd.i_lo) begin
      hi_q <= prod[48:0];
    end
    if (cmd.i_hi) begin
      pmag_q <= imag_sum;
    end
    if (cmd.sum) begin
      imag_q <= imag_sum[49:1];
      part_q <= {{4{prev_cmd[47]}}, prev_cmd} + pterm;
    end
    if (cmd.commit) begin
      res.drive_command     <= cmd_sat;
      res.setpoint_position <= sp_q;
      res.setpoint_velocity <= vel_q;
      res.setpoint_accel    <= acc_q;
      res.position_error    <= err_q;
    end
  end

  // Controller memory: last error and last command
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      prev_cmd <= '0;
    end else if (cmd.commit) begin
      prev_err <= err_q;
      prev_cmd <= cmd_sat;
    end
  end

endmodule

/* rtl/ramp_setpoint_pi_controller.sv */
// Top level: ramp setpoint generator with a Tustin PI position controller.
//
//   channel  dir  payload                                         handshake
//   sample   in   time_now, measured_position                     valid/ready
//   result   out  drive_command, setpoint_position,               valid/ready
//                 setpoint_velocity, setpoint_accel, position_error
//   apb      in   register writes and reads at byte address 4*i   psel/penable, pready=1
//
// One request runs through one accept step and twelve sequencer steps, set by
// the single shared 33x24 multiplier that forms all seven products in turn.
// The result register frees the input side: the next request is accepted while the
// previous result still waits; a stalled result holds the sequencer in its last step.
// rst (synchronous) restores the register defaults, clears the last error and
// command, and drops result valid.
module ramp_setpoint_pi_controller (
  input  logic                       clk,
  input  logic                       rst,
  rsp_in_if.sink                     sample,
  rsp_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsp_pkg::ADDR_W-1:0] paddr,
  input  logic [rsp_pkg::DATA_W-1:0] pwdata,
  output logic [rsp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  rsp_pkg::cfg_t    cfg;
  rsp_pkg::dp_cmd_t dp_cmd;
  rsp_pkg::result_t res;
  logic             in_ready;
  logic             out_valid;

  rsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: one request at a time, result valid owned here
  rsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .cmd       (dp_cmd)
  );

  // Datapath: setpoint, error, and the incremental PI update
  rsp_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (dp_cmd),
    .cfg     (cfg),
    .in_time (sample.time_now),
    .in_meas (sample.measured_position),
    .res     (res)
  );

  assign sample.ready             = in_ready;
  assign result.valid             = out_valid;
  assign result.drive_command     = res.drive_command;
  assign result.setpoint_position = res.setpoint_position;
  assign result.setpoint_velocity = res.setpoint_velocity;
  assign result.setpoint_accel    = res.setpoint_accel;
  assign result.position_error    = res.position_error;

  // Drop ready right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("request accepted while another is in flight");

  // A committed step always presents a result next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit |=> result.valid)
    else $error("commit without a valid result");

  // Never drive two datapath steps at once
  a_single_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0(dp_cmd))
    else $error("more than one datapath step active");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.commit |-> (!result.valid || result.ready))
    else $error("result overwritten while stalled");

endmodule
